FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is asserted.
`define TWAL_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("twal assertion failed");

// Concurrent check that also holds across reset.
`define TWAL_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("twal assertion failed");

`endif

FILE: hw/rtl/twal_pkg.sv
`timescale 1ns / 1ps

package twal_pkg;

    localparam int unsigned SAMPLE_W       = 28;
    localparam int unsigned FRAC_W         = 8;
    localparam int unsigned OUT_W          = SAMPLE_W + FRAC_W;
    localparam int unsigned CH_W           = 2;
    localparam int unsigned NUM_CH         = 3;
    localparam int unsigned CFG_IDX_W      = 2;
    localparam int unsigned CFG_DATA_W     = SAMPLE_W;
    localparam int unsigned LIMIT_W        = 4;
    localparam int unsigned DIR_W          = 5;
    localparam int unsigned WINDOW_LEN_DEF = 10;

    // Quotient bits produced per divider step.
    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned DIV_STEPS = OUT_W / DIGIT_W;

    localparam int unsigned RATIO_STEP  = 50000;
    localparam int unsigned RATIO_CAP   = 16;
    localparam int unsigned RATIO_SHIFT = $clog2(RATIO_CAP);
    localparam int unsigned RATIO_W     = RATIO_SHIFT + 1;

    localparam logic [CH_W-1:0] CH_HUMIDITY = 2'd1;
    localparam logic [CH_W-1:0] CH_INVALID  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_JUMP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd1;

    localparam logic [SAMPLE_W-1:0] JUMP_RESET  = 28'd800000;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET = 4'd10;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_SHIFT = 2'd1,
        CELL_LOAD  = 2'd2
    } t_cell_op;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        t_cell_op        op;
    } t_cell_ctl;

endpackage

FILE: hw/rtl/twal_cell.sv
`timescale 1ns / 1ps

module twal_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  twal_pkg::t_cell_ctl           i_ctl,
    input  logic [twal_pkg::SAMPLE_W-1:0] i_prev,
    input  logic [twal_pkg::SAMPLE_W-1:0] i_fill,
    output logic [twal_pkg::SAMPLE_W-1:0] o_entry
);
    import twal_pkg::*;

    // One window position for each channel.
    logic [SAMPLE_W-1:0] r_entry [NUM_CH];

    assign o_entry = (i_ctl.ch < CH_W'(NUM_CH)) ? r_entry[i_ctl.ch] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_entry[c] <= '0;
            end
        end else if (i_ctl.ch < CH_W'(NUM_CH)) begin
            case (i_ctl.op)
                CELL_SHIFT: r_entry[i_ctl.ch] <= i_prev;
                CELL_LOAD:  r_entry[i_ctl.ch] <= i_fill;
                default:    ;
            endcase
        end
    end

endmodule

FILE: hw/rtl/twal_div.sv
`timescale 1ns / 1ps

module twal_div #(
    parameter int unsigned WINDOW_LEN = twal_pkg::WINDOW_LEN_DEF
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  i_start,
    input  logic [twal_pkg::SAMPLE_W+$clog2(WINDOW_LEN)-1:0]      i_num,
    output logic                                                  o_done,
    output logic [twal_pkg::OUT_W-1:0]                            o_quot
);
    import twal_pkg::*;

    localparam int unsigned Divisor = WINDOW_LEN - 2;
    localparam int unsigned REM_W   = $clog2(Divisor);
    localparam int unsigned PART_W  = REM_W + DIGIT_W;
    localparam int unsigned STEP_W  = $clog2(DIV_STEPS);

    logic                     r_busy;
    logic                     r_done;
    logic [STEP_W-1:0]        r_cnt;
    logic [REM_W-1:0]         r_rem;
    logic [OUT_W-1:0]         r_num;
    logic [OUT_W-1:0]         r_quot;
    logic [PART_W-1:0]        w_part;
    logic [DIGIT_W-1:0]       w_digit;
    logic [REM_W-1:0]         w_rem;

    // The remainder stays below the divisor, so each digit is found by
    // comparing the partial value against the constant multiples of it.
    assign w_part = {r_rem, r_num[OUT_W-1 -: DIGIT_W]};

    always_comb begin
        w_digit = '0;
        for (int k = 1; k < (1 << DIGIT_W); k++) begin
            if (w_part >= PART_W'(k * Divisor)) begin
                w_digit = DIGIT_W'(k);
            end
        end
    end

    assign w_rem = REM_W'(w_part - PART_W'(w_digit) * PART_W'(Divisor));

    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == STEP_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // The dividend is the numerator shifted up by the fraction bits; its bits
    // above the quotient width always form a value below the divisor.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= REM_W'(i_num >> SAMPLE_W);
            r_num <= {i_num[SAMPLE_W-1:0], {FRAC_W{1'b0}}};
        end else if (r_busy) begin
            r_rem  <= w_rem;
            r_num  <= r_num << DIGIT_W;
            r_quot <= {r_quot[OUT_W-DIGIT_W-1:0], w_digit};
        end
    end

endmodule

FILE: hw/rtl/twal_lpf.sv
`timescale 1ns / 1ps

module twal_lpf (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [twal_pkg::OUT_W-1:0]    i_n,
    input  logic [twal_pkg::SAMPLE_W-1:0] i_jump,
    input  logic [twal_pkg::LIMIT_W-1:0]  i_limit,
    output logic                          o_done,
    output logic [twal_pkg::OUT_W-1:0]    o_result
);
    import twal_pkg::*;

    localparam int unsigned PROD_W = OUT_W + RATIO_W;

    logic                     r_v1;
    logic                     r_v2;
    logic                     r_v3;
    logic                     r_done;
    logic [OUT_W-1:0]         r_prev;
    logic signed [DIR_W-1:0]  r_dir;
    logic [OUT_W-1:0]         r_n;
    logic                     r_rise;
    logic [OUT_W-1:0]         r_delta;
    logic                     r_pass;
    logic [RATIO_W-1:0]       r_ratio;
    logic [OUT_W-1:0]         r_step;

    logic                     w_pass;
    logic                     w_apply;
    logic signed [DIR_W-1:0]  n_dir;
    logic signed [DIR_W:0]    w_dir_x;
    logic signed [DIR_W:0]    w_lim_x;
    logic [SAMPLE_W-1:0]      w_delta8;
    logic [RATIO_W-1:0]       w_ratio;
    logic [PROD_W-1:0]        w_prod;
    logic [OUT_W-1:0]         w_res;

    assign w_dir_x  = $signed({r_dir[DIR_W-1], r_dir});
    assign w_lim_x  = $signed({2'b00, i_limit});
    assign w_delta8 = r_delta[OUT_W-1:FRAC_W];

    assign w_pass = (r_n == '0) || (r_n == r_prev)
                 || (r_delta > {i_jump, {FRAC_W{1'b0}}});

    // Run counter: a reversal clears it, a full run enables the speed-up.
    always_comb begin
        n_dir   = r_dir;
        w_apply = 1'b0;
        if (r_rise) begin
            if (w_dir_x < 0) begin
                n_dir = '0;
            end else if (w_dir_x >= w_lim_x) begin
                w_apply = 1'b1;
            end else begin
                n_dir = r_dir + DIR_W'(1);
            end
        end else begin
            if (w_dir_x > 0) begin
                n_dir = '0;
            end else if (w_dir_x <= -w_lim_x) begin
                w_apply = 1'b1;
            end else begin
                n_dir = r_dir - DIR_W'(1);
            end
        end
    end

    // floor(delta / (RATIO_STEP * 256)) + 1, capped, as a count of
    // thresholds passed by the integer part of delta; 1 without the speed-up.
    always_comb begin
        logic [RATIO_W-1:0] cnt;
        cnt = RATIO_W'(1);
        for (int k = 1; k < RATIO_CAP; k++) begin
            if (w_delta8 >= SAMPLE_W'(k * RATIO_STEP)) begin
                cnt = cnt + RATIO_W'(1);
            end
        end
        w_ratio = w_apply ? cnt : RATIO_W'(1);
    end

    assign w_prod = {{RATIO_W{1'b0}}, r_delta} * {{OUT_W{1'b0}}, r_ratio};
    assign w_res  = r_pass ? r_n : (r_rise ? r_prev + r_step : r_prev - r_step);

    assign o_done   = r_done;
    assign o_result = r_prev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_done <= 1'b0;
            r_prev <= '0;
            r_dir  <= '0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_done <= r_v3;
            if (r_v1 && !w_pass) begin
                r_dir <= n_dir;
            end
            if (r_v3) begin
                r_prev <= w_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n     <= i_n;
            r_rise  <= i_n > r_prev;
            r_delta <= (i_n > r_prev) ? i_n - r_prev : r_prev - i_n;
        end
        if (r_v1) begin
            r_pass  <= w_pass;
            r_ratio <= w_ratio;
        end
        if (r_v2) begin
            r_step <= w_prod[OUT_W+RATIO_SHIFT-1:RATIO_SHIFT];
        end
    end

endmodule

FILE: hw/rtl/trimmed_window_adaptive_lowpass_core.sv
`timescale 1ns / 1ps

// Trimmed-window filter for three sensor channels with an adaptive low-pass
// on the humidity channel.
// Input channel: i_in_valid / o_in_ready with i_channel and i_sample. One
// item is worked on at a time; o_in_ready is high only while the core idles.
// Output channel: o_out_valid / i_out_ready with o_filtered (Q.8). The
// result sits in an output register, so the next item is accepted while a
// result still waits to be taken. A stalled receiver holds the finished
// item in the core until the output register frees up.
// Configuration: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index and
// i_cfg_data; write it only while the core is idle.
// Sequence: the window of WINDOW_LEN-1 cells is walked once, one cell per
// cycle, then a radix-16 divider takes nine steps, and a humidity item
// then passes the low-pass. An item on channel three skips the window and
// returns zero.
// Reset clears all windows, the low-pass state, the run counter and restores
// the configuration defaults; no clearing pass is needed.
module trimmed_window_adaptive_lowpass_core #(
    parameter int unsigned WINDOW_LEN = twal_pkg::WINDOW_LEN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [twal_pkg::CH_W-1:0]       i_channel,
    input  logic [twal_pkg::SAMPLE_W-1:0]   i_sample,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [twal_pkg::OUT_W-1:0]      o_filtered,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [twal_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [twal_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import twal_pkg::*;

    localparam int unsigned N_CELLS = WINDOW_LEN - 1;
    localparam int unsigned CNT_W   = $clog2(WINDOW_LEN);
    localparam int unsigned SUM_W   = SAMPLE_W + $clog2(WINDOW_LEN);
    localparam int unsigned HALF    = (WINDOW_LEN - 2) / 2;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_WALK = 5'b00010,
        S_DIV  = 5'b00100,
        S_LPF  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [CH_W-1:0]     r_ch;
    logic [SAMPLE_W-1:0] r_s;
    logic                r_fill;
    logic [SUM_W-1:0]    r_sum;
    logic [SAMPLE_W-1:0] r_max;
    logic [SAMPLE_W-1:0] r_min;
    logic [OUT_W-1:0]    r_res;
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out;
    logic [SAMPLE_W-1:0] r_jump;
    logic [LIMIT_W-1:0]  r_limit;

    t_cell_ctl           w_cell_ctl;
    logic [SAMPLE_W-1:0] w_entry [N_CELLS];
    logic [SAMPLE_W-1:0] w_head_in;
    logic [SAMPLE_W-1:0] w_tail;
    logic                w_fill_now;
    logic [SAMPLE_W-1:0] w_val;
    logic [SUM_W-1:0]    w_trim;
    logic                w_div_start;
    logic                w_div_done;
    logic [OUT_W-1:0]    w_quot;
    logic                w_lpf_start;
    logic                w_lpf_done;
    logic [OUT_W-1:0]    w_lpf_res;
    logic                w_out_free;
    logic                w_accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_out;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_out_ready;

    // The window rotates once through the row so that every stored sample
    // passes the tail; an empty newest entry means the window is refilled.
    assign w_tail     = w_entry[N_CELLS-1];
    assign w_fill_now = (r_cnt == '0) ? (w_entry[0] == '0) : r_fill;
    assign w_val      = w_fill_now ? r_s : w_tail;
    assign w_trim     = r_sum - SUM_W'(r_max) - SUM_W'(r_min) + SUM_W'(HALF);

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        if (g == 0) begin : g_head
            twal_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_cell_ctl),
                .i_prev  (w_head_in),
                .i_fill  (r_s),
                .o_entry (w_entry[g])
            );
        end else begin : g_body
            twal_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_cell_ctl),
                .i_prev  (w_entry[g-1]),
                .i_fill  (r_s),
                .o_entry (w_entry[g])
            );
        end
    end

    twal_div #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_trim),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    twal_lpf u_lpf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_lpf_start),
        .i_n      (w_quot),
        .i_jump   (r_jump),
        .i_limit  (r_limit),
        .o_done   (w_lpf_done),
        .o_result (w_lpf_res)
    );

    always_comb begin
        n_state        = r_state;
        w_cell_ctl.ch  = r_ch;
        w_cell_ctl.op  = CELL_HOLD;
        w_head_in      = w_tail;
        w_div_start    = 1'b0;
        w_lpf_start    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_channel == CH_INVALID) ? S_DONE : S_WALK;
                end
            end
            S_WALK: begin
                if (r_cnt == CNT_W'(N_CELLS)) begin
                    // Shift the new sample in, or refill the whole window.
                    w_cell_ctl.op = r_fill ? CELL_LOAD : CELL_SHIFT;
                    w_head_in     = r_s;
                    w_div_start   = 1'b1;
                    n_state       = S_DIV;
                end else begin
                    w_cell_ctl.op = CELL_SHIFT;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    if (r_ch == CH_HUMIDITY) begin
                        w_lpf_start = 1'b1;
                        n_state     = S_LPF;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_LPF: begin
                if (w_lpf_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_jump      <= JUMP_RESET;
            r_limit     <= LIMIT_RESET;
        end else begin
            r_state <= n_state;
            if (w_accept || r_state != S_WALK) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_JUMP:  r_jump  <= i_cfg_data;
                    CFG_LIMIT: r_limit <= i_cfg_data[LIMIT_W-1:0];
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ch  <= i_channel;
            r_s   <= i_sample;
            r_sum <= SUM_W'(i_sample);
            r_max <= i_sample;
            r_min <= i_sample;
            r_res <= '0;
        end
        if (r_state == S_WALK && r_cnt != CNT_W'(N_CELLS)) begin
            r_fill <= w_fill_now;
            r_sum  <= r_sum + SUM_W'(w_val);
            if (w_val > r_max) begin
                r_max <= w_val;
            end
            if (w_val < r_min) begin
                r_min <= w_val;
            end
        end
        if (r_state == S_DIV && w_div_done && r_ch != CH_HUMIDITY) begin
            r_res <= w_quot;
        end
        if (r_state == S_LPF && w_lpf_done) begin
            r_res <= w_lpf_res;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out <= r_res;
        end
    end

endmodule

FILE: hw/rtl/twal_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module twal_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic [twal_pkg::CH_W-1:0]       i_channel,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [twal_pkg::OUT_W-1:0]      o_filtered
);
    import twal_pkg::*;

    logic w_in_acc;
    logic w_out_stall;
    logic w_bad_acc;

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_stall = o_out_valid && !i_out_ready;
    assign w_bad_acc   = w_in_acc && (i_channel == CH_INVALID) && !o_out_valid;

    // A result waiting on the receiver keeps its value.
    `TWAL_ASSERT(a_out_hold, i_clk, i_rst_n, w_out_stall |=> o_out_valid && $stable(o_filtered))

    // Reset empties the output and leaves the core ready for an item.
    `TWAL_ASSERT_ALWAYS(a_reset, i_clk, !i_rst_n |=> !o_out_valid && o_in_ready)

    // Only one item is in flight at a time.
    `TWAL_ASSERT(a_one_item, i_clk, i_rst_n, w_in_acc |=> !o_in_ready)

    // An item on the unused channel, taken while no result waits, returns zero.
    `TWAL_ASSERT(a_bad_ch, i_clk, i_rst_n, w_bad_acc |-> ##2 (o_out_valid && o_filtered == '0))

    // A new result appears only as the core goes back to idle.
    `TWAL_ASSERT(a_new_result, i_clk, i_rst_n, $rose(o_out_valid) |-> o_in_ready)

endmodule

bind trimmed_window_adaptive_lowpass_core twal_checker u_twal_checker (.*);
